/* hdl/sdac_pkg.sv */
package sdac_pkg;

    // line symbols
    localparam logic [7:0] SYM_END     = 8'hC0;
    localparam logic [7:0] SYM_ESC     = 8'hDB;
    localparam logic [7:0] SYM_ESC_END = 8'hDC;
    localparam logic [7:0] SYM_ESC_ESC = 8'hDD;

    // configuration registers
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_ENABLE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_CAPACITY = 2'd1;
    localparam logic        RX_ENABLE_RESET      = 1'b1;
    localparam logic [15:0] FRAME_CAPACITY_RESET = 16'd256;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        CMD_DATA = 1'b0,
        CMD_END  = 1'b1
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t   kind;
        logic        abort;
        logic [7:0]  data;
    } cmd_t;

    typedef struct packed
    {
        logic                   valid;
        logic                   full;
        logic [QUEUE_LVL_W-1:0] level;
    } queue_stat_t;

    typedef enum logic
    {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } item_kind_t;

    typedef enum logic [1:0]
    {
        STATUS_GOOD      = 2'd0,
        STATUS_BAD_SUM   = 2'd1,
        STATUS_ABORTED   = 2'd2,
        STATUS_TOO_SHORT = 2'd3
    } frame_status_t;

endpackage

/* hdl/sdac_front.sv */
module sdac_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    input  logic                 rx_enable,
    input  sdac_pkg::queue_stat_t q_stat,
    output logic                 push,
    output sdac_pkg::cmd_t       cmd
);

    logic escape_reg;
    logic escape_next;
    logic accept;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready && rx_enable;

    // escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= 1'b0;
        end
        else
        begin
            escape_reg <= escape_next;
        end
    end

    // classify the incoming word
    always_comb
    begin
        escape_next = escape_reg;
        push        = 1'b0;
        cmd.kind    = sdac_pkg::CMD_DATA;
        cmd.abort   = 1'b0;
        cmd.data    = rx_byte;
        if (accept)
        begin
            priority if (rx_byte == sdac_pkg::SYM_END)
            begin
                push        = 1'b1;
                cmd.kind    = sdac_pkg::CMD_END;
                cmd.abort   = escape_reg;
                escape_next = 1'b0;
            end
            else if (rx_byte == sdac_pkg::SYM_ESC)
            begin
                escape_next = 1'b1;
            end
            else if (escape_reg)
            begin
                escape_next = 1'b0;
                if (rx_byte == sdac_pkg::SYM_ESC_ESC)
                begin
                    push     = 1'b1;
                    cmd.data = sdac_pkg::SYM_ESC;
                end
                else if (rx_byte == sdac_pkg::SYM_ESC_END)
                begin
                    push     = 1'b1;
                    cmd.data = sdac_pkg::SYM_END;
                end
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

endmodule

/* hdl/sdac_queue.sv */
module sdac_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sdac_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output sdac_pkg::cmd_t        head_cmd,
    output sdac_pkg::queue_stat_t stat
);

    sdac_pkg::cmd_t                       entry_reg [sdac_pkg::QUEUE_DEPTH];
    logic [sdac_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [sdac_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [sdac_pkg::QUEUE_LVL_W-1:0]     level_reg;
    logic                                 do_push;
    logic                                 do_pop;

    assign stat.level = level_reg;
    assign stat.valid = (level_reg != '0);
    assign stat.full  = (level_reg == sdac_pkg::QUEUE_LVL_W'(sdac_pkg::QUEUE_DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/sdac_back.sv */
module sdac_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdac_pkg::queue_stat_t q_stat,
    input  sdac_pkg::cmd_t        head_cmd,
    output logic                  pop,
    input  logic [15:0]           frame_capacity,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  item_kind,
    output logic [7:0]            payload_byte,
    output logic [1:0]            frame_status,
    output logic [15:0]           payload_length
);

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  older_reg;
    logic [7:0]  older_next;
    logic [7:0]  newer_reg;
    logic [7:0]  newer_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    sdac_pkg::item_kind_t    kind_reg;
    sdac_pkg::item_kind_t    kind_next;
    logic [7:0]              byte_reg;
    logic [7:0]              byte_next;
    sdac_pkg::frame_status_t status_reg;
    sdac_pkg::frame_status_t status_next;
    logic [15:0]             length_reg;
    logic [15:0]             length_next;

    logic        have_two;
    logic [15:0] expect_sum;

    assign pop            = q_stat.valid && (!out_valid_reg || out_ready);
    assign have_two       = (count_reg >= 16'd2);
    assign expect_sum     = 16'd0 - sum_reg;
    assign out_valid      = out_valid_reg;
    assign item_kind      = kind_reg;
    assign payload_byte   = byte_reg;
    assign frame_status   = status_reg;
    assign payload_length = length_reg;

    // frame state and output word
    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        older_next     = older_reg;
        newer_next     = newer_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        status_next    = status_reg;
        length_next    = length_reg;
        if (restart)
        begin
            count_next = '0;
            sum_next   = '0;
            older_next = '0;
            newer_next = '0;
        end
        else if (pop)
        begin
            unique case (head_cmd.kind)
                sdac_pkg::CMD_END:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = sdac_pkg::KIND_END;
                    byte_next      = '0;
                    length_next    = have_two ? count_reg - 16'd2 : 16'd0;
                    priority if (head_cmd.abort)
                    begin
                        status_next = sdac_pkg::STATUS_ABORTED;
                    end
                    else if (!have_two)
                    begin
                        status_next = sdac_pkg::STATUS_TOO_SHORT;
                    end
                    else if (expect_sum == {newer_reg, older_reg})
                    begin
                        status_next = sdac_pkg::STATUS_GOOD;
                    end
                    else
                    begin
                        status_next = sdac_pkg::STATUS_BAD_SUM;
                    end
                    count_next = '0;
                    sum_next   = '0;
                    older_next = '0;
                    newer_next = '0;
                end
                sdac_pkg::CMD_DATA:
                begin
                    if (count_reg < frame_capacity)
                    begin
                        older_next = newer_reg;
                        newer_next = head_cmd.data;
                        count_next = count_reg + 16'd1;
                        if (have_two)
                        begin
                            sum_next       = sum_reg + {8'd0, older_reg};
                            out_valid_next = 1'b1;
                            kind_next      = sdac_pkg::KIND_PAYLOAD;
                            byte_next      = older_reg;
                            status_next    = sdac_pkg::STATUS_GOOD;
                            length_next    = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            older_reg     <= '0;
            newer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            older_reg     <= older_next;
            newer_reg     <= newer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        length_reg <= length_next;
    end

endmodule

/* hdl/slip_deframer_additive_check.sv */
// SLIP receive deframer with 16-bit additive checksum.
// Input channel (in_valid/in_ready, rx_byte): one raw line word per handshake.
// Output channel (out_valid/out_ready): payload words (item_kind 0) stream
// out as decoded; the last two stored bytes of a frame are held back as the
// little-endian checksum. An END closes the frame with one report word
// (item_kind 1) carrying frame_status and payload_length. Frames that do not
// end good must be discarded downstream.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
// rx_enable, index 1 frame_capacity (write also restarts the frame);
// other indexes are ignored. cfg_ready is always high.
// Throughput: one word per cycle while the command queue is not full. A
// result passes the four-entry command queue between the classifier and the
// frame datapath, then the output register, before it is shown.
// When the receiver stalls the queue fills and in_ready drops once it holds
// four commands; a waiting result does not stop the next word from being accepted.
// Reset: rx_enable 1, frame_capacity 256, no escape pending, empty frame,
// queue empty, out_valid low.
module slip_deframer_additive_check
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               item_kind,
    output logic [7:0]                         payload_byte,
    output logic [1:0]                         frame_status,
    output logic [15:0]                        payload_length,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sdac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sdac_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                  rx_enable_reg;
    logic [15:0]           capacity_reg;
    logic                  cfg_write;
    logic                  restart;
    logic                  push;
    logic                  pop;
    sdac_pkg::cmd_t        push_cmd;
    sdac_pkg::cmd_t        head_cmd;
    sdac_pkg::queue_stat_t q_stat;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write && (cfg_index == sdac_pkg::CFG_FRAME_CAPACITY);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_enable_reg <= sdac_pkg::RX_ENABLE_RESET;
            capacity_reg  <= sdac_pkg::FRAME_CAPACITY_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == sdac_pkg::CFG_RX_ENABLE)
            begin
                rx_enable_reg <= cfg_data[0];
            end
            if (cfg_index == sdac_pkg::CFG_FRAME_CAPACITY)
            begin
                capacity_reg <= cfg_data[15:0];
            end
        end
    end

    // classifier
    sdac_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .rx_enable (rx_enable_reg),
        .q_stat    (q_stat),
        .push      (push),
        .cmd       (push_cmd)
    );

    // command queue
    sdac_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // frame datapath
    sdac_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .frame_capacity (capacity_reg),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .item_kind      (item_kind),
        .payload_byte   (payload_byte),
        .frame_status   (frame_status),
        .payload_length (payload_length)
    );

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= sdac_pkg::QUEUE_LVL_W'(sdac_pkg::QUEUE_DEPTH))
        else $error("command queue overfilled");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == sdac_pkg::KIND_PAYLOAD)
        |-> (frame_status == sdac_pkg::STATUS_GOOD) && (payload_length == 16'd0))
        else $error("payload word carries report fields");

    a_short_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == sdac_pkg::KIND_END)
        && (frame_status == sdac_pkg::STATUS_TOO_SHORT)
        |-> (payload_length == 16'd0) && (payload_byte == 8'd0))
        else $error("short frame report with nonzero length");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.valid && (!out_valid || out_ready))
        else $error("queue popped with no room for the result");

endmodule

/* sim/slip_deframer_additive_check_tb.sv */
`timescale 1ns / 100ps

module slip_deframer_additive_check_tb;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MODE_ITEMS    = 600;
    localparam int SESSION_ITEMS = 60;

    // register indexes that the block ignores
    localparam logic [sdac_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [sdac_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum
    {
        FRAME_GOOD,
        FRAME_CORRUPT,
        FRAME_ABORT
    } frame_flavor_t;

    typedef struct
    {
        sdac_pkg::item_kind_t    kind;
        logic [7:0]              data;
        sdac_pkg::frame_status_t status;
        logic [15:0]             length;
    } deframe_word_t;

    typedef struct
    {
        logic [7:0]    line_byte;
        bit            pinned;
        bit            has_word;
        deframe_word_t word;
    } stim_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [7:0]                       rx_byte;
    logic                             out_valid;
    logic                             out_ready;
    logic                             item_kind;
    logic [7:0]                       payload_byte;
    logic [1:0]                       frame_status;
    logic [15:0]                      payload_length;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [sdac_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sdac_pkg::CFG_DATA_W-1:0]  cfg_data;

    // deframer shadow state
    logic        rx_on;
    logic [15:0] capacity;
    logic        esc_seen;
    logic [15:0] kept_count;
    logic [15:0] payload_sum;
    logic [7:0]  hold_old;
    logic [7:0]  hold_new;

    deframe_word_t expected_words[$];
    stim_row_t     stim_rows[$];

    int words_in;
    int words_cfg;
    int items_sent;
    int quiet_cycles;
    int error_count;
    int send_idle_pct;
    int recv_idle_pct;

    // typed expectation for the directed word being sent
    bit            pin_row;
    bit            pin_has;
    deframe_word_t pin_word;

    slip_deframer_additive_check uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .item_kind      (item_kind),
        .payload_byte   (payload_byte),
        .frame_status   (frame_status),
        .payload_length (payload_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // frame restart
    task automatic clear_frame();
        kept_count  = '0;
        payload_sum = '0;
        hold_old    = '0;
        hold_new    = '0;
    endtask

    // one line byte through the shadow deframer
    task automatic deframe_byte(input logic [7:0] line_byte, output bit produced,
                                output deframe_word_t w);
        logic [7:0]  c;
        logic [7:0]  leaving;
        logic [15:0] want_sum;
        c        = line_byte;
        produced = 1'b0;
        w        = '{sdac_pkg::KIND_PAYLOAD, 8'h00, sdac_pkg::STATUS_GOOD, 16'h0000};
        if (!rx_on)
            return;
        // end closes the frame with a report
        if (c == sdac_pkg::SYM_END)
        begin
            produced = 1'b1;
            w.kind   = sdac_pkg::KIND_END;
            w.length = (kept_count >= 16'd2) ? kept_count - 16'd2 : 16'd0;
            want_sum = 16'd0 - payload_sum;
            if (esc_seen)
            begin
                w.status = sdac_pkg::STATUS_ABORTED;
                esc_seen = 1'b0;
            end
            else if (kept_count < 16'd2)
                w.status = sdac_pkg::STATUS_TOO_SHORT;
            else if ({hold_new, hold_old} == want_sum)
                w.status = sdac_pkg::STATUS_GOOD;
            else
                w.status = sdac_pkg::STATUS_BAD_SUM;
            clear_frame();
            return;
        end
        if (c == sdac_pkg::SYM_ESC)
        begin
            esc_seen = 1'b1;
            return;
        end
        // escaped symbol, unknown ones are dropped
        if (esc_seen)
        begin
            esc_seen = 1'b0;
            if (c == sdac_pkg::SYM_ESC_ESC)
                c = sdac_pkg::SYM_ESC;
            else if (c == sdac_pkg::SYM_ESC_END)
                c = sdac_pkg::SYM_END;
            else
                return;
        end
        // two-byte hold back, older byte streams out
        if (kept_count < capacity)
        begin
            leaving  = hold_old;
            hold_old = hold_new;
            hold_new = c;
            if (kept_count >= 16'd2)
            begin
                payload_sum = payload_sum + 16'(leaving);
                produced    = 1'b1;
                w.data      = leaving;
            end
            kept_count = kept_count + 16'd1;
        end
    endtask

    task automatic apply_register(input logic [sdac_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [15:0] val);
        if (idx == sdac_pkg::CFG_RX_ENABLE)
            rx_on = val[0];
        else if (idx == sdac_pkg::CFG_FRAME_CAPACITY)
        begin
            capacity = val;
            clear_frame();
        end
    endtask

    // handshake monitor, scoreboard and watchdog
    always @(posedge clk)
    begin
        deframe_word_t want;
        deframe_word_t got;
        bit            produced;
        if (rst_n)
        begin
            // result words against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error({"unexpected word: item_kind %0d payload_byte %0h ",
                            "frame_status %0d payload_length %0d"},
                           item_kind, payload_byte, frame_status, payload_length);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (item_kind !== want.kind)
                    begin
                        $error("item_kind expected %0d actual %0d", want.kind, item_kind);
                        error_count++;
                    end
                    if (payload_byte !== want.data)
                    begin
                        $error("payload_byte expected %0h actual %0h", want.data, payload_byte);
                        error_count++;
                    end
                    if (frame_status !== want.status)
                    begin
                        $error("frame_status expected %0d actual %0d", want.status, frame_status);
                        error_count++;
                    end
                    if (payload_length !== want.length)
                    begin
                        $error("payload_length expected %0d actual %0d", want.length,
                               payload_length);
                        error_count++;
                    end
                end
            end
            // accepted line word
            if (in_valid && in_ready)
            begin
                deframe_byte(rx_byte, produced, got);
                if (pin_row)
                begin
                    if (pin_has)
                        expected_words.push_back(pin_word);
                end
                else if (produced)
                    expected_words.push_back(got);
                words_in++;
            end
            // register write
            if (cfg_valid && cfg_ready)
            begin
                apply_register(cfg_index, cfg_data);
                words_cfg++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("slip_deframer_additive_check_tb NOT OK");
                    $finish;
                end
            end
        end
    end

    // receiver back pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic send_byte(input logic [7:0] b);
        int target;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        if (rx_on)
            items_sent++;
        target = words_in + 1;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(negedge clk); while (words_in < target);
    endtask

    // escape one decoded byte onto the line
    task automatic send_coded(input logic [7:0] d);
        if (d == sdac_pkg::SYM_END)
        begin
            send_byte(sdac_pkg::SYM_ESC);
            send_byte(sdac_pkg::SYM_ESC_END);
        end
        else if (d == sdac_pkg::SYM_ESC)
        begin
            send_byte(sdac_pkg::SYM_ESC);
            send_byte(sdac_pkg::SYM_ESC_ESC);
        end
        else
            send_byte(d);
    endtask

    task automatic send_frame(input int len, input frame_flavor_t flavor);
        logic [15:0] acc;
        logic [15:0] chk;
        logic [7:0]  d;
        acc = '0;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                d = $urandom_range(0, 1) ? sdac_pkg::SYM_END : sdac_pkg::SYM_ESC;
            else
                d = 8'($urandom_range(0, 255));
            acc = acc + 16'(d);
            send_coded(d);
        end
        chk = 16'd0 - acc;
        if (flavor == FRAME_CORRUPT)
            chk = chk ^ (16'd1 << $urandom_range(0, 15));
        send_coded(chk[7:0]);
        send_coded(chk[15:8]);
        if (flavor == FRAME_ABORT)
            send_byte(sdac_pkg::SYM_ESC);
        send_byte(sdac_pkg::SYM_END);
    endtask

    // raw words biased toward the line symbols
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 4))
                0: send_byte(sdac_pkg::SYM_END);
                1: send_byte(sdac_pkg::SYM_ESC);
                2: send_byte(sdac_pkg::SYM_ESC_END);
                3: send_byte(sdac_pkg::SYM_ESC_ESC);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // hold off until every expected word is out and the queue has drained
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_put(input logic [sdac_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] val);
        int target;
        target = words_cfg + 1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (words_cfg < target);
    endtask

    task automatic program_block(input bit enable, input bit set_cap,
                                 input logic [15:0] cap_val);
        cfg_put(sdac_pkg::CFG_RX_ENABLE, {15'($urandom), enable});
        if (set_cap)
            cfg_put(sdac_pkg::CFG_FRAME_CAPACITY, cap_val);
        if ($urandom_range(0, 3) == 0)
            cfg_put($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // one setting, then a run of frames and noise
    task automatic run_session();
        int            budget;
        int            len;
        int            pick;
        logic [15:0]   cap_val;
        frame_flavor_t flavor;
        settle_block();
        case ($urandom_range(0, 11))
            0: cap_val = 16'd0;
            1: cap_val = 16'd1;
            2: cap_val = 16'd2;
            3: cap_val = 16'd3;
            4: cap_val = 16'hFFFF;
            5: cap_val = 16'($urandom_range(4, 12));
            6: cap_val = 16'($urandom);
            default: cap_val = sdac_pkg::FRAME_CAPACITY_RESET;
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            // receiver off for a while, words are dropped
            program_block(1'b0, 1'b1, cap_val);
            send_noise(12);
            settle_block();
            program_block(1'b1, 1'b0, 16'h0000);
        end
        else
            program_block(1'b1, 1'b1, cap_val);
        budget = items_sent + SESSION_ITEMS;
        while (items_sent < budget)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_noise($urandom_range(1, 6));
            else
            begin
                if (pick <= 3)
                    flavor = FRAME_CORRUPT;
                else if (pick <= 5)
                    flavor = FRAME_ABORT;
                else
                    flavor = FRAME_GOOD;
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 300)
                                                   : $urandom_range(0, 14);
                send_frame(len, flavor);
            end
        end
    endtask

    function automatic stim_row_t open_row(input logic [7:0] b);
        stim_row_t r;
        r.line_byte = b;
        r.pinned    = 1'b0;
        r.has_word  = 1'b0;
        r.word      = '{sdac_pkg::KIND_PAYLOAD, 8'h00, sdac_pkg::STATUS_GOOD, 16'h0000};
        return r;
    endfunction

    function automatic stim_row_t pinned_row(input logic [7:0] b, input bit has,
                                             input sdac_pkg::item_kind_t k,
                                             input logic [7:0] d,
                                             input sdac_pkg::frame_status_t s,
                                             input logic [15:0] len);
        stim_row_t r;
        r.line_byte = b;
        r.pinned    = 1'b1;
        r.has_word  = has;
        r.word      = '{k, d, s, len};
        return r;
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = sdac_pkg::CFG_RX_ENABLE;
        cfg_data      = '0;
        words_in      = 0;
        words_cfg     = 0;
        items_sent    = 0;
        quiet_cycles  = 0;
        error_count   = 0;
        send_idle_pct = 23;
        recv_idle_pct = 57;
        pin_row       = 1'b0;
        pin_has       = 1'b0;
        pin_word      = '{sdac_pkg::KIND_PAYLOAD, 8'h00, sdac_pkg::STATUS_GOOD, 16'h0000};
        rx_on         = sdac_pkg::RX_ENABLE_RESET;
        capacity      = sdac_pkg::FRAME_CAPACITY_RESET;
        esc_seen      = 1'b0;
        clear_frame();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // end right after reset, then an aborted empty frame
        stim_rows.push_back(pinned_row(sdac_pkg::SYM_END, 1'b1, sdac_pkg::KIND_END, 8'h00,
                                       sdac_pkg::STATUS_TOO_SHORT, 16'd0));
        stim_rows.push_back(pinned_row(sdac_pkg::SYM_ESC, 1'b0, sdac_pkg::KIND_PAYLOAD, 8'h00,
                                       sdac_pkg::STATUS_GOOD, 16'd0));
        stim_rows.push_back(pinned_row(sdac_pkg::SYM_END, 1'b1, sdac_pkg::KIND_END, 8'h00,
                                       sdac_pkg::STATUS_ABORTED, 16'd0));
        // good frame with extreme payload values, checksum ff00
        stim_rows.push_back(open_row(8'h00));
        stim_rows.push_back(open_row(8'hFF));
        stim_rows.push_back(pinned_row(8'h01, 1'b1, sdac_pkg::KIND_PAYLOAD, 8'h00,
                                       sdac_pkg::STATUS_GOOD, 16'd0));
        stim_rows.push_back(pinned_row(8'h00, 1'b1, sdac_pkg::KIND_PAYLOAD, 8'hFF,
                                       sdac_pkg::STATUS_GOOD, 16'd0));
        stim_rows.push_back(pinned_row(8'hFF, 1'b1, sdac_pkg::KIND_PAYLOAD, 8'h01,
                                       sdac_pkg::STATUS_GOOD, 16'd0));
        stim_rows.push_back(pinned_row(sdac_pkg::SYM_END, 1'b1, sdac_pkg::KIND_END, 8'h00,
                                       sdac_pkg::STATUS_GOOD, 16'd3));
        // both escapes, an unknown escape, a doubled escape, bad checksum
        stim_rows.push_back(open_row(sdac_pkg::SYM_ESC));
        stim_rows.push_back(open_row(sdac_pkg::SYM_ESC_END));
        stim_rows.push_back(open_row(sdac_pkg::SYM_ESC));
        stim_rows.push_back(open_row(sdac_pkg::SYM_ESC_ESC));
        stim_rows.push_back(open_row(sdac_pkg::SYM_ESC));
        stim_rows.push_back(open_row(8'h41));
        stim_rows.push_back(open_row(sdac_pkg::SYM_ESC));
        stim_rows.push_back(open_row(sdac_pkg::SYM_ESC));
        stim_rows.push_back(open_row(sdac_pkg::SYM_ESC_END));
        stim_rows.push_back(open_row(8'h00));
        stim_rows.push_back(open_row(8'h00));
        stim_rows.push_back(pinned_row(sdac_pkg::SYM_END, 1'b1, sdac_pkg::KIND_END, 8'h00,
                                       sdac_pkg::STATUS_BAD_SUM, 16'd3));
        // single stored byte is too short
        stim_rows.push_back(open_row(8'h7F));
        stim_rows.push_back(pinned_row(sdac_pkg::SYM_END, 1'b1, sdac_pkg::KIND_END, 8'h00,
                                       sdac_pkg::STATUS_TOO_SHORT, 16'd0));

        foreach (stim_rows[i])
        begin
            pin_row  = stim_rows[i].pinned;
            pin_has  = stim_rows[i].has_word;
            pin_word = stim_rows[i].word;
            send_byte(stim_rows[i].line_byte);
        end
        pin_row = 1'b0;

        // random frames under three idle patterns
        for (int mode = 0; mode < 3; mode++)
        begin
            if (mode == 1)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 23;
            end
            else if (mode == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (items_sent < (mode + 1) * MODE_ITEMS)
                run_session();
        end

        settle_block();
        if (error_count == 0)
            $display("slip_deframer_additive_check_tb OK");
        else
            $display("slip_deframer_additive_check_tb NOT OK");
        $finish;
    end

endmodule
